FILE: design/pairwise_repulsion_acceleration_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the repulsion accelerator
// Concurrent checks clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_REPULSION_ACCELERATION_MACROS_SVH
`define PAIRWISE_REPULSION_ACCELERATION_MACROS_SVH

// property holds at every edge
`define PRA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg
// Constants, register codes and sequencer states of the repulsion accelerator.
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

  localparam int MAX_BODIES = 16;
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);
  localparam int IDX_W      = $clog2(MAX_BODIES);

  localparam int POS_W      = 24;
  localparam int ACC_W      = 24;
  localparam int BIDX_W     = 6;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 48;
  localparam int DEN_W      = 45;
  localparam int QUO_W      = 40;
  localparam int DIV_STEPS  = QUO_W;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT = 2'd1;

  localparam logic [CFG_W-1:0] GAIN_RESET = 24'd26214;
  localparam logic [CFG_W-1:0] SOFT_RESET = 24'd39322;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_RDI,
    ST_PI,
    ST_RDJ,
    ST_DIFF,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_SQRT,
    ST_CUB0,
    ST_CUB1,
    ST_CUB2,
    ST_CUB3,
    ST_CUB4,
    ST_DEN,
    ST_DIV,
    ST_ACC,
    ST_SC0,
    ST_SC1,
    ST_SC2,
    ST_SC3,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: design/pairwise_repulsion_acceleration.sv
// Loading: one body word per cycle, taken only while no set is being worked on.
// Set: each pair of distinct bodies passes through the bit-pair square root
// and then the three parallel dividers.
// One result word per body, one 26x26 multiplier shared by all products.
// rst (synchronous) empties the set and restores gain and softening; the
// position memory is not cleared.
// ----------------------------------------------------------------------------
// pairwise_repulsion_acceleration
// Stores body positions, then sums softened pair repulsions per body.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pairwise_repulsion_acceleration_macros.svh"

module pairwise_repulsion_acceleration
  import pra_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [71:0]          s_tdata,   // pos_x, pos_y, pos_z
  input  wire logic                 s_tlast,   // last_body
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [79:0]               m_tdata,   // body_index, accel_x, accel_y, accel_z, pad
  output logic                      m_tuser,   // overflow
  output logic                      m_tlast    // last_result
);

  state_t state, state_next;

  logic [CFG_W-1:0] gain, softening;
  logic [CNT_W-1:0] count, i, j;
  logic             dropped;

  logic [3*POS_W-1:0] mem [MAX_BODIES];
  logic [3*POS_W-1:0] mem_q;
  logic [IDX_W-1:0]   mem_ra;
  logic               mem_we;

  logic [25:0] mul_a, mul_b;
  logic [51:0] mul_p;

  logic signed [POS_W-1:0] pi [3];
  logic [POS_W-1:0]        ad [3];
  logic                    an [3];
  logic [49:0]             d2;
  logic [49:0]             sq_v, sq_res, sq_bit;
  logic [25:0]             mag;
  logic [33:0]             sqm;
  logic [42:0]             cb_lo;
  logic [43:0]             cube;
  logic [DEN_W-1:0]        den, den_c;
  logic [DEN_W-1:0]        dv_rem [3];
  logic [QUO_W-1:0]        dv_q [3];
  logic [DEN_W-1:0]        rem_n [3];
  logic [QUO_W-1:0]        q_n [3];
  logic [5:0]              div_cnt;
  logic signed [SUM_W-1:0] sums [3];
  logic [1:0]              sc_ax;
  logic [39:0]             sc_mag;
  logic                    sc_neg;
  logic [43:0]             sc_lo;
  logic [ACC_W-1:0]        acc [3];
  logic                    out_load;
  logic                    last_i;

  logic [49:0]             sq_tr;
  logic [59:0]             cb_full;
  logic [63:0]             sc_prod;
  logic [47:0]             sc_r;
  logic [SUM_W-1:0]        sc_abs;
  logic signed [24:0]      diff [3];

  assign cfg_ready = 1'b1;
  assign last_i    = (i + CNT_W'(1)) == count;
  assign mem_we    = (state == ST_LOAD) && s_tvalid && (count < CNT_W'(MAX_BODIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_RESET;
      softening <= SOFT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN: gain      <= cfg_data;
        REG_SOFT: softening <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IDX_W-1:0]] <= s_tdata;
    end
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_comb begin
    sq_tr   = sq_res + sq_bit;
    cb_full = 60'(cb_lo) + {mul_p[42:0], 17'b0};
    den_c   = {1'b0, cube} + DEN_W'(softening);
    sc_prod = 64'(sc_lo) + {mul_p[43:0], 20'b0};
    sc_r    = sc_prod[63:16];
    sc_abs  = sums[sc_ax][SUM_W-1] ? SUM_W'(-sums[sc_ax]) : SUM_W'(sums[sc_ax]);
    for (int k = 0; k < 3; k++) begin
      diff[k] = 25'(pi[k]) - 25'($signed(mem_q[POS_W*k +: POS_W]));
      if ({dv_rem[k], dv_q[k][QUO_W-1]} >= {1'b0, den}) begin
        rem_n[k] = DEN_W'({dv_rem[k], dv_q[k][QUO_W-1]} - {1'b0, den});
        q_n[k]   = {dv_q[k][QUO_W-2:0], 1'b1};
      end else begin
        rem_n[k] = {dv_rem[k][DEN_W-2:0], dv_q[k][QUO_W-1]};
        q_n[k]   = {dv_q[k][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_ra     = '0;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid && s_tlast) begin
          state_next = ST_RDI;
        end
      end
      ST_RDI: begin
        mem_ra     = i[IDX_W-1:0];
        state_next = ST_PI;
      end
      ST_PI: state_next = ST_RDJ;
      ST_RDJ: begin
        mem_ra = j[IDX_W-1:0];
        if (j == count) begin
          state_next = ST_SC0;
        end else if (j != i) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: state_next = ST_SQ0;
      ST_SQ0: begin
        mul_a      = 26'(ad[0]);
        mul_b      = 26'(ad[0]);
        state_next = ST_SQ1;
      end
      ST_SQ1: begin
        mul_a      = 26'(ad[1]);
        mul_b      = 26'(ad[1]);
        state_next = ST_SQ2;
      end
      ST_SQ2: begin
        mul_a      = 26'(ad[2]);
        mul_b      = 26'(ad[2]);
        state_next = ST_SQ3;
      end
      ST_SQ3: state_next = ST_SQRT;
      ST_SQRT: begin
        if (sq_bit[0]) begin
          state_next = ST_CUB0;
        end
      end
      ST_CUB0: begin
        mul_a      = sq_res[25:0];
        mul_b      = sq_res[25:0];
        state_next = ST_CUB1;
      end
      ST_CUB1: state_next = ST_CUB2;
      ST_CUB2: begin
        mul_a      = 26'(sqm[16:0]);
        mul_b      = mag;
        state_next = ST_CUB3;
      end
      ST_CUB3: begin
        mul_a      = 26'(sqm[33:17]);
        mul_b      = mag;
        state_next = ST_CUB4;
      end
      ST_CUB4: state_next = ST_DEN;
      ST_DEN: state_next = (den_c == '0) ? ST_ACC : ST_DIV;
      ST_DIV: begin
        if (div_cnt == 6'(DIV_STEPS - 1)) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: state_next = ST_RDJ;
      ST_SC0: state_next = ST_SC1;
      ST_SC1: begin
        mul_a      = 26'(sc_mag[19:0]);
        mul_b      = 26'(gain);
        state_next = ST_SC2;
      end
      ST_SC2: begin
        mul_a      = 26'(sc_mag[39:20]);
        mul_b      = 26'(gain);
        state_next = ST_SC3;
      end
      ST_SC3: state_next = (sc_ax == 2'd2) ? ST_OUT : ST_SC0;
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = last_i ? ST_LOAD : ST_RDI;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      i       <= '0;
      j       <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          i <= '0;
          if (s_tvalid) begin
            if (count < CNT_W'(MAX_BODIES)) begin
              count <= count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        ST_PI: j <= '0;
        ST_RDJ: begin
          if (j == i) begin
            j <= j + CNT_W'(1);
          end
        end
        ST_ACC: j <= j + CNT_W'(1);
        ST_OUT: begin
          if (out_load) begin
            if (last_i) begin
              count   <= '0;
              dropped <= 1'b0;
            end else begin
              i <= i + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // pair datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_PI: begin
        for (int k = 0; k < 3; k++) begin
          pi[k]   <= $signed(mem_q[POS_W*k +: POS_W]);
          sums[k] <= '0;
        end
      end
      ST_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          an[k] <= diff[k][24];
          ad[k] <= diff[k][24] ? 24'(-diff[k]) : diff[k][23:0];
        end
      end
      ST_SQ1: d2 <= 50'(mul_p[47:0]);
      ST_SQ2: d2 <= d2 + 50'(mul_p[47:0]);
      ST_SQ3: begin
        sq_v   <= d2 + 50'(mul_p[47:0]);
        sq_res <= '0;
        sq_bit <= 50'(1) << 48;
      end
      ST_SQRT: begin
        if (sq_v >= sq_tr) begin
          sq_v   <= sq_v - sq_tr;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      ST_CUB0: mag <= sq_res[25:0];
      ST_CUB1: sqm <= mul_p[49:16];
      ST_CUB3: cb_lo <= mul_p[42:0];
      ST_CUB4: cube <= cb_full[59:16];
      ST_DEN: begin
        den     <= den_c;
        div_cnt <= '0;
        for (int k = 0; k < 3; k++) begin
          dv_rem[k] <= '0;
          dv_q[k]   <= (den_c == '0) ? '0 : {ad[k], 16'b0};
        end
      end
      ST_DIV: begin
        div_cnt <= div_cnt + 6'd1;
        for (int k = 0; k < 3; k++) begin
          dv_rem[k] <= rem_n[k];
          dv_q[k]   <= q_n[k];
        end
      end
      ST_ACC: begin
        for (int k = 0; k < 3; k++) begin
          sums[k] <= an[k] ? sums[k] - $signed(SUM_W'(dv_q[k]))
                           : sums[k] + $signed(SUM_W'(dv_q[k]));
        end
      end
      ST_RDI: sc_ax <= '0;
      ST_SC0: begin
        sc_neg <= sums[sc_ax][SUM_W-1];
        sc_mag <= (sc_abs > (SUM_W'(1) << 39)) ? (40'(1) << 39) : sc_abs[39:0];
      end
      ST_SC2: sc_lo <= mul_p[43:0];
      ST_SC3: begin
        if (sc_neg) begin
          acc[sc_ax] <= (sc_r > 48'h800000) ? 24'h800000 : 24'(-sc_r);
        end else begin
          acc[sc_ax] <= (sc_r > 48'h7FFFFF) ? 24'h7FFFFF : sc_r[23:0];
        end
        sc_ax <= sc_ax + 2'd1;
      end
      default: ;
    endcase
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b0, acc[2], acc[1], acc[0], BIDX_W'(i)};
      m_tuser <= dropped;
      m_tlast <= last_i;
    end
  end

  `PRA_ASSERT_ALWAYS(a_count_range, count <= CNT_W'(MAX_BODIES), "body count past capacity")
  `PRA_ASSERT_NEXT(a_set_start, s_tvalid && s_tready && s_tlast, state == ST_RDI && count != '0, "set closed without bodies")
  `PRA_ASSERT_NEXT(a_set_end, out_load && last_i, state == ST_LOAD && count == '0 && !dropped, "set not cleared after last word")
  `PRA_ASSERT_NEXT(a_self_skip, state == ST_RDJ && j == i, state == ST_RDJ, "self pair entered datapath")

endmodule

`default_nettype wire

FILE: verif/pairwise_repulsion_acceleration_tb.sv
// ----------------------------------------------------------------------------
// pairwise_repulsion_acceleration_tb
// Loads sets of bodies, predicts the softened repulsion of every body against
// the rest in exact fixed point, and checks each result word in order.
// ----------------------------------------------------------------------------
`default_nettype none

import pra_pkg::*;

typedef struct {
  logic [BIDX_W-1:0] idx;
  logic [ACC_W-1:0]  ax;
  logic [ACC_W-1:0]  ay;
  logic [ACC_W-1:0]  az;
  logic              ovf;
  logic              last;
} accel_word_t;

class accel_scoreboard;
  logic signed [POS_W-1:0] bx[MAX_BODIES];
  logic signed [POS_W-1:0] by[MAX_BODIES];
  logic signed [POS_W-1:0] bz[MAX_BODIES];
  int unsigned             nbodies;
  bit                      dropped;
  longint unsigned         gain;
  longint unsigned         softening;
  accel_word_t             pending[$];
  int                      errors;
  int                      results;

  function new();
    nbodies   = 0;
    dropped   = 0;
    gain      = GAIN_RESET;
    softening = SOFT_RESET;
    errors    = 0;
    results   = 0;
  endfunction

  task report(string what);
    errors++;
    if (errors <= 20) $display("MISMATCH %0t: %s", $time, what);
  endtask

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    if (idx == REG_GAIN) gain = val;
    else if (idx == REG_SOFT) softening = val;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function longint axis_term(longint d, longint unsigned den);
    longint unsigned q;
    if (den == 0) return 0;
    q = ((d < 0 ? -d : d) << 16) / den;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function logic [ACC_W-1:0] scale_acc(longint s);
    longint unsigned m;
    longint r;
    if (s > (64'sd1 <<< 39)) s = 64'sd1 <<< 39;
    if (s < -(64'sd1 <<< 39)) s = -(64'sd1 <<< 39);
    m = s < 0 ? -s : s;
    m = (m * gain) >> 16;
    if (m > 64'd8388608) m = 64'd8388608;
    r = s < 0 ? -longint'(m) : longint'(m);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[ACC_W-1:0];
  endfunction

  function void note_body(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                          logic [POS_W-1:0] z, logic lst);
    longint sx, sy, sz, dx, dy, dz;
    longint unsigned d2, mag, cube;
    accel_word_t w;
    if (nbodies < MAX_BODIES) begin
      bx[nbodies] = x;
      by[nbodies] = y;
      bz[nbodies] = z;
      nbodies++;
    end else begin
      dropped = 1;
    end
    if (!lst) return;
    for (int i = 0; i < nbodies; i++) begin
      sx = 0; sy = 0; sz = 0;
      for (int j = 0; j < nbodies; j++) begin
        if (i == j) continue;
        dx = longint'(bx[i]) - longint'(bx[j]);
        dy = longint'(by[i]) - longint'(by[j]);
        dz = longint'(bz[i]) - longint'(bz[j]);
        d2 = dx * dx + dy * dy + dz * dz;
        mag = int_sqrt(d2);
        cube = (((mag * mag) >> 16) * mag) >> 16;
        sx += axis_term(dx, cube + softening);
        sy += axis_term(dy, cube + softening);
        sz += axis_term(dz, cube + softening);
      end
      w.idx  = BIDX_W'(i);
      w.ax   = scale_acc(sx);
      w.ay   = scale_acc(sy);
      w.az   = scale_acc(sz);
      w.ovf  = dropped;
      w.last = (i + 1 == nbodies);
      pending = {pending, w};
    end
    nbodies = 0;
    dropped = 0;
  endfunction

  task check_result(accel_word_t got);
    accel_word_t e;
    results++;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result word for body %0d", got.idx));
      return;
    end
    e = pending.pop_front();
    if (got.idx !== e.idx) report($sformatf("index %0d, want %0d", got.idx, e.idx));
    if (got.ax !== e.ax) report($sformatf("body %0d accel_x %h, want %h", e.idx, got.ax, e.ax));
    if (got.ay !== e.ay) report($sformatf("body %0d accel_y %h, want %h", e.idx, got.ay, e.ay));
    if (got.az !== e.az) report($sformatf("body %0d accel_z %h, want %h", e.idx, got.az, e.az));
    if (got.ovf !== e.ovf) report($sformatf("body %0d overflow %b", e.idx, got.ovf));
    if (got.last !== e.last) report($sformatf("body %0d last %b", e.idx, got.last));
  endtask
endclass

module pairwise_repulsion_acceleration_tb;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;
  localparam logic [POS_W-1:0] POS_MAX = 24'h7FFFFF;
  localparam logic [POS_W-1:0] POS_MIN = 24'h800000;
  localparam logic [POS_W-1:0] ONE     = 24'h010000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [71:0]          s_tdata;   // pos_x, pos_y, pos_z
  logic                 s_tlast;   // last_body
  logic                 m_tvalid;
  logic                 m_tready;
  logic [79:0]          m_tdata;   // body_index, accel_x, accel_y, accel_z, pad
  logic                 m_tuser;   // overflow
  logic                 m_tlast;   // last_result

  accel_scoreboard sb;
  bit              quiet;
  int              bodies_sent;
  int              sets_sent;
  int              overflow_sets;
  int              cfg_writes;
  accel_word_t     got;

  pairwise_repulsion_acceleration dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.idx  = m_tdata[5:0];
      got.ax   = m_tdata[29:6];
      got.ay   = m_tdata[53:30];
      got.az   = m_tdata[77:54];
      got.ovf  = m_tuser;
      got.last = m_tlast;
      sb.check_result(got);
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= quiet || ($urandom_range(0, 99) >= 10);
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task send_body(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z,
                 logic lst);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 10) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    sb.note_body(x, y, z, lst);
    bodies_sent++;
    if (lst) sets_sent++;
    @(negedge clk);
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(negedge clk);
  endtask

  function logic [CFG_W-1:0] pick_reg();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CFG_W'($urandom_range(0, 16'hFFFF));
      3: return CFG_W'($urandom_range(1, 24'h0FFFFF));
      default: return CFG_W'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  task random_set();
    int n;
    int r;
    int k;
    logic [POS_W-1:0] cx, cy, cz;
    bit wide;
    r = $urandom_range(0, 99);
    if (r < 85) n = $urandom_range(1, 6);
    else if (r < 96) n = $urandom_range(7, MAX_BODIES);
    else n = $urandom_range(MAX_BODIES + 1, MAX_BODIES + 3);
    if (n > MAX_BODIES) overflow_sets++;
    wide = ($urandom_range(0, 99) < 15);
    k  = $urandom_range(4, 20);
    cx = POS_W'($urandom_range(0, 24'hFFFFFF));
    cy = POS_W'($urandom_range(0, 24'hFFFFFF));
    cz = POS_W'($urandom_range(0, 24'hFFFFFF));
    for (int i = 0; i < n; i++) begin
      if (wide)
        send_body(POS_W'($urandom_range(0, 24'hFFFFFF)),
                  POS_W'($urandom_range(0, 24'hFFFFFF)),
                  POS_W'($urandom_range(0, 24'hFFFFFF)), i == n - 1);
      else
        send_body(POS_W'(cx + $urandom_range(0, 1 << k) - (1 << (k - 1))),
                  POS_W'(cy + $urandom_range(0, 1 << k) - (1 << (k - 1))),
                  POS_W'(cz + $urandom_range(0, 1 << k) - (1 << (k - 1))), i == n - 1);
    end
    drain();
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    quiet = 0;
    bodies_sent = 0;
    sets_sent = 0;
    overflow_sets = 0;
    cfg_writes = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset gain and softening
    send_body(POS_MAX, POS_MIN, ONE, 1'b1);
    drain();
    send_body(POS_MAX, POS_MAX, POS_MAX, 1'b0);
    send_body(POS_MIN, POS_MIN, POS_MIN, 1'b1);
    drain();
    send_body('0, '0, '0, 1'b0);
    send_body(ONE, '0, '0, 1'b0);
    send_body('0, -ONE, ONE, 1'b1);
    drain();

    // coincident bodies with no softening: zero denominator
    write_reg(REG_SOFT, '0);
    write_reg(REG_GAIN, '1);
    send_body(24'd1, 24'd2, 24'd3, 1'b0);
    send_body(24'd1, 24'd2, 24'd3, 1'b0);
    send_body(ONE, ONE << 1, -(ONE >> 1), 1'b1);
    drain();

    write_reg(REG_GAIN, '0);
    write_reg(REG_SOFT, '1);
    write_reg(REG_SPARE2, '1);
    write_reg(REG_SPARE3, 24'h123456);
    send_body(ONE, '0, '0, 1'b0);
    send_body('0, ONE, '0, 1'b1);
    drain();

    write_reg(REG_GAIN, GAIN_RESET);
    write_reg(REG_SOFT, SOFT_RESET);

    while (bodies_sent < 420) begin
      quiet = (bodies_sent >= 150 && bodies_sent < 230);
      if ($urandom_range(0, 99) < 15) begin
        write_reg(CFG_IDX_W'($urandom_range(0, 3)), pick_reg());
        if ($urandom_range(0, 1)) write_reg(REG_SOFT, pick_reg());
      end
      random_set();
    end
    quiet = 0;
    drain();

    $display("Covered %0d bodies in %0d sets (%0d over capacity), %0d register writes,",
             bodies_sent, sets_sent, overflow_sets, cfg_writes);
    $display("and checked %0d acceleration words.", sb.results);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

`default_nettype wire

FILE: pairwise_repulsion_acceleration.f
+incdir+design
design/pra_pkg.sv
design/pairwise_repulsion_acceleration.sv
verif/pairwise_repulsion_acceleration_tb.sv
